// ----- rtl/core/owb_pkg.sv -----
// Package for the 1-Wire bus decoder: widths, symbol kinds, register indexes
// and the structs passed between the timer, the judge and the top level.
// No dependencies.
package owb_pkg;

  localparam int CNT_W  = 24;   // pulse / gap counters and thresholds
  localparam int TICK_W = 32;   // free-running tick and output times
  localparam int BYTE_W = 8;
  localparam int BIT_W  = 3;    // bit index within a byte
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Symbol kinds
  localparam logic [KIND_W-1:0] KIND_RESET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESENCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SHORT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_GAP_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN     = 3'd5;

  // Reset values of the thresholds
  localparam logic [CNT_W-1:0] RESET_MIN_DEF    = 24'd480;
  localparam logic [CNT_W-1:0] RESET_SHORT_DEF  = 24'd450;
  localparam logic [CNT_W-1:0] PRES_GAP_MAX_DEF = 24'd60;
  localparam logic [CNT_W-1:0] PRES_MIN_DEF     = 24'd60;
  localparam logic [CNT_W-1:0] ONE_MAX_DEF      = 24'd15;
  localparam logic [CNT_W-1:0] ZERO_MIN_DEF     = 24'd60;

  typedef struct packed {
    logic [CNT_W-1:0] reset_min;
    logic [CNT_W-1:0] reset_short;
    logic [CNT_W-1:0] pres_gap_max;
    logic [CNT_W-1:0] pres_min;
    logic [CNT_W-1:0] one_max;
    logic [CNT_W-1:0] zero_min;
  } cfg_t;

  // Line timing as seen by the judge for the current sample
  typedef struct packed {
    logic              pulse_end;   // sample high after a low one
    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] low_start;
    logic [CNT_W-1:0]  low_count;
    logic [CNT_W-1:0]  gap_count;
  } timing_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] length;
  } result_t;

endpackage

// ----- rtl/core/owb_timer.sv -----
// Line timer: previous level, tick counter, low pulse start/length and gap.
// Depends on owb_pkg.
module owb_timer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              line_level,
  output owb_pkg::timing_t  timing
);
  import owb_pkg::*;

  logic              prev_r,      prev_nxt;
  logic [TICK_W-1:0] tick_r,      tick_nxt;
  logic [TICK_W-1:0] low_start_r, low_start_nxt;
  logic [CNT_W-1:0]  low_cnt_r,   low_cnt_nxt;
  logic [CNT_W-1:0]  gap_cnt_r,   gap_cnt_nxt;

  assign timing.pulse_end = line_level & ~prev_r;
  assign timing.tick_now  = tick_r;
  assign timing.low_start = low_start_r;
  assign timing.low_count = low_cnt_r;
  assign timing.gap_count = gap_cnt_r;

  always_comb begin
    prev_nxt      = line_level;
    tick_nxt      = tick_r + 1'b1;
    low_start_nxt = low_start_r;
    low_cnt_nxt   = low_cnt_r;
    gap_cnt_nxt   = gap_cnt_r;
    if (line_level) begin
      if (!prev_r) begin
        gap_cnt_nxt = {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (gap_cnt_r != CNT_MAX) begin
        gap_cnt_nxt = gap_cnt_r + 1'b1;
      end
    end else begin
      if (prev_r) begin
        low_start_nxt = tick_r;
        low_cnt_nxt   = {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (low_cnt_r != CNT_MAX) begin
        low_cnt_nxt = low_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= 1'b1;
      tick_r      <= '0;
      low_start_r <= '0;
      low_cnt_r   <= '0;
      gap_cnt_r   <= '0;
    end else if (advance) begin
      prev_r      <= prev_nxt;
      tick_r      <= tick_nxt;
      low_start_r <= low_start_nxt;
      low_cnt_r   <= low_cnt_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
    end
  end

  // While the line is low the running pulse has at least one sample
  a_low_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !prev_r |-> low_cnt_r != '0)
    else $error("low pulse counter empty while line low");

endmodule

// ----- rtl/core/owb_judge.sv -----
// Pulse judge: idle/detect/data phase machine, byte assembly and result build.
// Depends on owb_pkg; fed by owb_timer.
module owb_judge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  owb_pkg::cfg_t     cfg,
  input  owb_pkg::timing_t  timing,
  output owb_pkg::result_t  res
);
  import owb_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DETECT = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  logic [1:0]        phase_r,      phase_nxt;
  logic [BIT_W-1:0]  bits_r,       bits_nxt;
  logic [BYTE_W-1:0] shift_r,      shift_nxt;
  logic [TICK_W-1:0] byte_start_r, byte_start_nxt;

  logic [TICK_W-1:0] dur;
  logic [TICK_W-1:0] bstart;
  logic [BYTE_W-1:0] shifted;
  logic              use_idle;
  logic              idle_short, idle_full;
  logic              bit_one, bit_zero;
  logic [CNT_W-1:0]  len, gap;

  assign len        = timing.low_count;
  assign gap        = timing.gap_count;
  assign dur        = timing.tick_now - timing.low_start;
  assign idle_short = (len < cfg.reset_min) && (len > cfg.reset_short);
  assign idle_full  = len >= cfg.reset_min;
  assign bit_one    = len < cfg.one_max;
  assign bit_zero   = len > cfg.zero_min;
  assign bstart     = (bits_r == '0) ? timing.low_start : byte_start_r;
  assign shifted    = {bit_one, shift_r[BYTE_W-1:1]};

  always_comb begin
    phase_nxt      = phase_r;
    bits_nxt       = bits_r;
    shift_nxt      = shift_r;
    byte_start_nxt = byte_start_r;
    use_idle       = 1'b0;
    res.valid      = 1'b0;
    res.kind       = KIND_ERROR;
    res.value      = '0;
    res.start      = timing.low_start;
    res.length     = dur;

    if (timing.pulse_end) begin
      unique case (phase_r)
        PH_DETECT: begin
          if (gap > cfg.pres_gap_max) begin
            use_idle = 1'b1;          // presence came too late: judge as idle
          end else if (len < cfg.pres_min) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            phase_nxt = PH_IDLE;
          end else begin
            res.valid = 1'b1;
            res.kind  = KIND_PRESENCE;
            phase_nxt = PH_DATA;
            bits_nxt  = '0;
            shift_nxt = '0;
          end
        end
        PH_DATA: begin
          if (len > cfg.reset_short) begin
            bits_nxt  = '0;           // drop the partial byte
            shift_nxt = '0;
            use_idle  = 1'b1;
          end else begin
            byte_start_nxt = bstart;
            if (!bit_one && !bit_zero) begin
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
              phase_nxt = PH_IDLE;
              bits_nxt  = '0;
              shift_nxt = '0;
            end else if (bits_r == {BIT_W{1'b1}}) begin
              res.valid  = 1'b1;
              res.kind   = KIND_DATA;
              res.value  = shifted;
              res.start  = bstart;
              res.length = timing.tick_now - bstart;
              bits_nxt   = '0;
              shift_nxt  = '0;
            end else begin
              bits_nxt  = bits_r + 1'b1;
              shift_nxt = shifted;
            end
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase

      if (use_idle) begin
        res.valid = 1'b1;
        priority if (idle_short) begin
          res.kind  = KIND_RESET;
          res.value = {{(BYTE_W-1){1'b0}}, 1'b1};
          phase_nxt = PH_DETECT;
        end else if (idle_full) begin
          res.kind  = KIND_RESET;
          phase_nxt = PH_DETECT;
        end else begin
          res.kind  = KIND_ERROR;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bits_r       <= '0;
      shift_r      <= '0;
      byte_start_r <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      bits_r       <= bits_nxt;
      shift_r      <= shift_nxt;
      byte_start_r <= byte_start_nxt;
    end
  end

  // A partial byte exists only while in the data phase
  a_bits_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r != '0 |-> phase_r == PH_DATA)
    else $error("bit count held outside data phase");

  a_shift_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r != '0 |-> phase_r == PH_DATA)
    else $error("shift byte held outside data phase");

  // Results only come at the end of a low pulse
  a_res_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> timing.pulse_end)
    else $error("result without pulse end");

endmodule

// ----- rtl/core/one_wire_bus_decoder.sv -----
// 1-Wire bus decoder: one line sample per beat in, reset/presence/byte/error out.
// A result is on the output register in the cycle after the sample that ends it.
// Throughput: one sample per cycle; the input stalls only while a result waits stalled.
// Reset (rst_n, synchronous): line assumed high, tick and counters zero, idle phase,
// thresholds back to 480/450/60/60/15/60 ticks, output empty.
// Depends on owb_pkg, owb_timer, owb_judge.
module one_wire_bus_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_line_level,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [owb_pkg::KIND_W-1:0]      out_symbol_kind,
  output logic [owb_pkg::BYTE_W-1:0]      out_symbol_value,
  output logic [owb_pkg::TICK_W-1:0]      out_start_tick,
  output logic [owb_pkg::TICK_W-1:0]      out_length_ticks,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owb_pkg::CNT_W-1:0]       cfg_data
);
  import owb_pkg::*;

  cfg_t    cfg_r;
  timing_t timing;
  result_t res;
  logic    in_acc;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_value_r;
  logic [TICK_W-1:0] out_start_r;
  logic [TICK_W-1:0] out_len_r;

  // Hold the input only when a finished result is blocked downstream;
  // otherwise the output register drains and refills in the same cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_min    <= RESET_MIN_DEF;
      cfg_r.reset_short  <= RESET_SHORT_DEF;
      cfg_r.pres_gap_max <= PRES_GAP_MAX_DEF;
      cfg_r.pres_min     <= PRES_MIN_DEF;
      cfg_r.one_max      <= ONE_MAX_DEF;
      cfg_r.zero_min     <= ZERO_MIN_DEF;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to indexes past the register list
      unique case (cfg_index)
        REG_RESET_MIN:    cfg_r.reset_min    <= cfg_data;
        REG_RESET_SHORT:  cfg_r.reset_short  <= cfg_data;
        REG_PRES_GAP_MAX: cfg_r.pres_gap_max <= cfg_data;
        REG_PRES_MIN:     cfg_r.pres_min     <= cfg_data;
        REG_ONE_MAX:      cfg_r.one_max      <= cfg_data;
        REG_ZERO_MIN:     cfg_r.zero_min     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Time the low pulses and the gaps between them
  owb_timer u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_acc),
    .line_level (in_line_level),
    .timing     (timing)
  );

  // Judge each finished pulse and build the result
  owb_judge u_judge (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .cfg     (cfg_r),
    .timing  (timing),
    .res     (res)
  );

  // Output register: load on a beat that yields a result, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
      out_start_r <= res.start;
      out_len_r   <= res.length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_kind  = out_kind_r;
  assign out_symbol_value = out_value_r;
  assign out_start_tick   = out_start_r;
  assign out_length_ticks = out_len_r;

  // Input is held back only on account of a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  // A non-data symbol carries only the short-reset flag in bit 0, set only on a reset symbol
  a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_DATA |-> out_value_r[BYTE_W-1:1] == '0)
    else $error("non-data symbol carries byte bits");

endmodule
